@@ rtl/core/consistent_hash_ring_core_defines.svh @@
// assertion macros shared by the consistent hash ring rtl
`ifndef CONSISTENT_HASH_RING_CORE_DEFINES_SVH
`define CONSISTENT_HASH_RING_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define CHR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chr check failed");

// next-cycle implication
`define CHR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chr check failed");

`endif

@@ rtl/core/chr_pkg.sv @@
// types and codes shared by the consistent hash ring modules
package chr_pkg;

  localparam int unsigned KEY_W     = 32;
  localparam int unsigned OUT_TAG_W = 8;
  localparam int unsigned TAG_MAX_W = 16;
  localparam int unsigned STATUS_W  = 3;

  // opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_COLLIDED = 3'd4;

  // command broadcast to every cell
  typedef struct packed {
    logic             cmp_en;
    logic             wr_en;
    logic [KEY_W-1:0] key;
  } chr_cmd_t;

  // reduced answer of the whole row
  typedef struct packed {
    logic                 eq_any;
    logic                 ge_any;
    logic [KEY_W-1:0]     key;
    logic [TAG_MAX_W-1:0] tag;
  } chr_red_t;

endpackage

@@ rtl/core/consistent_hash_ring_core.sv @@
// consistent hash ring: sorted row of key cells with insert probing and lookup
//
// channel  dir  handshake                    tuser            tdata
// s_axis   in   s_axis_tvalid/s_axis_tready  opcode           key, node_tag
// m_axis   out  m_axis_tvalid/m_axis_tready  status           owner_tag, placed_key
//
// an item passes compare, two or-tree stages and decide before its result is registered;
// each collision probe runs compare, the two or-tree stages and decide again.
// reset clears the fill count and control; cell contents stay undefined.
// a result waiting on m_axis_tready holds the decide step but not intake.
`include "consistent_hash_ring_core_defines.svh"

module consistent_hash_ring_core #(
  parameter int unsigned RING_CAPACITY = 256,
  parameter int unsigned PROBE_LIMIT   = 32,
  parameter int unsigned TAG_BITS      = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // key[31:0], node_tag[39:32]
  input  logic        s_axis_tuser,   // opcode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // owner_tag[7:0], placed_key[39:8]
  output logic [2:0]  m_axis_tuser    // status[2:0]
);
  import chr_pkg::*;

  localparam int unsigned CNT_W = $clog2(RING_CAPACITY + 1);
  localparam int unsigned PRB_W = $clog2(PROBE_LIMIT + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CMP    = 5'b00010,
    S_RED1   = 5'b00100,
    S_RED2   = 5'b01000,
    S_DECIDE = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PRB_W-1:0]    prb_q, prb_d;
  logic                op_q, op_d;
  logic [KEY_W-1:0]    run_q, run_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [OUT_TAG_W-1:0] out_owner_q, out_owner_d;
  logic [KEY_W-1:0]    out_key_q, out_key_d;
  logic                out_room;
  logic                out_load;
  logic [TAG_MAX_W-1:0] in_tag_wide;
  logic [TAG_MAX_W-1:0] hit_tag_wide;
  chr_cmd_t            cmd;
  chr_red_t            red;

  logic [KEY_W-1:0]    cell_key [RING_CAPACITY];
  logic [TAG_BITS-1:0] cell_tag [RING_CAPACITY];
  logic [KEY_W-1:0]    sel_key  [RING_CAPACITY];
  logic [TAG_BITS-1:0] sel_tag  [RING_CAPACITY];
  logic [RING_CAPACITY-1:0] cell_ge, cell_eq, cell_hit;

  assign in_tag_wide = TAG_MAX_W'(s_axis_tdata[39:32]);

  // row of cells, each wired to its lower neighbor
  for (genvar i = 0; i < RING_CAPACITY; i++) begin : g_cell
    logic                prev_ge;
    logic [KEY_W-1:0]    prev_key;
    logic [TAG_BITS-1:0] prev_tag;
    if (i == 0) begin : g_first
      assign prev_ge  = 1'b0;
      assign prev_key = '0;
      assign prev_tag = '0;
    end else begin : g_rest
      assign prev_ge  = cell_ge[i-1];
      assign prev_key = cell_key[i-1];
      assign prev_tag = cell_tag[i-1];
    end
    chr_cell #(
      .INDEX   (i),
      .CNT_W   (CNT_W),
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .new_tag_i (tag_q),
      .count_i   (cnt_q),
      .prev_ge_i (prev_ge),
      .prev_key_i(prev_key),
      .prev_tag_i(prev_tag),
      .key_o     (cell_key[i]),
      .tag_o     (cell_tag[i]),
      .ge_o      (cell_ge[i]),
      .eq_o      (cell_eq[i]),
      .hit_o     (cell_hit[i]),
      .sel_key_o (sel_key[i]),
      .sel_tag_o (sel_tag[i])
    );
  end

  chr_reduce #(
    .N       (RING_CAPACITY),
    .TAG_BITS(TAG_BITS)
  ) u_reduce (
    .clk_i(clk_i),
    .eq_i (cell_eq),
    .ge_i (cell_ge),
    .key_i(sel_key),
    .tag_i(sel_tag),
    .red_o(red)
  );

  assign out_room      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // sequencer: compare, reduce, decide, probe again or finish
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    prb_d        = prb_q;
    op_d         = op_q;
    run_d        = run_q;
    tag_d        = tag_q;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_owner_d  = '0;
    out_key_d    = '0;
    cmd.cmp_en   = (state_q == S_CMP);
    cmd.wr_en    = 1'b0;
    cmd.key      = run_q;
    hit_tag_wide = red.ge_any ? red.tag : TAG_MAX_W'(cell_tag[0]);

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = s_axis_tuser;
          run_d   = s_axis_tdata[31:0];
          tag_d   = in_tag_wide[TAG_BITS-1:0];
          prb_d   = '0;
          state_d = S_CMP;
        end
      end
      S_CMP:  state_d = S_RED1;
      S_RED1: state_d = S_RED2;
      S_RED2: state_d = S_DECIDE;
      S_DECIDE: begin
        if (op_q == OP_INSERT) begin
          if (cnt_q == CNT_W'(RING_CAPACITY)) begin
            out_load     = out_room;
            out_status_d = ST_FULL;
          end else if (!red.eq_any) begin
            out_load     = out_room;
            cmd.wr_en    = out_room;
            out_status_d = ST_INSERTED;
            out_key_d    = run_q;
            if (out_room) begin
              cnt_d = cnt_q + CNT_W'(1);
            end
          end else if (prb_q == PRB_W'(PROBE_LIMIT)) begin
            out_load     = out_room;
            out_status_d = ST_COLLIDED;
          end else begin
            // next probe adds 2^i - 1 to the running key
            run_d   = run_q + ((KEY_W'(1) << prb_q) - KEY_W'(1));
            prb_d   = prb_q + PRB_W'(1);
            state_d = S_CMP;
          end
        end else begin
          out_load = out_room;
          if (cnt_q == '0) begin
            out_status_d = ST_EMPTY;
          end else begin
            out_status_d = ST_FOUND;
            out_key_d    = red.ge_any ? red.key : cell_key[0];
            out_owner_d  = hit_tag_wide[OUT_TAG_W-1:0];
          end
        end
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output holding register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      prb_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      prb_q       <= prb_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    run_q <= run_d;
    tag_q <= tag_d;
    if (out_load) begin
      out_status_q <= out_status_d;
      out_owner_q  <= out_owner_d;
      out_key_q    <= out_key_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_key_q, out_owner_q};

  // checks
  `CHR_ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(RING_CAPACITY))
  `CHR_ASSERT_NEXT(a_wr_count, clk_i, rst_ni, cmd.wr_en, cnt_q == $past(cnt_q) + CNT_W'(1))
  `CHR_ASSERT_IMPL(a_full_code, clk_i, rst_ni, out_load && (out_status_d == ST_FULL), cnt_q == CNT_W'(RING_CAPACITY))
  `CHR_ASSERT_IMPL(a_one_hit, clk_i, rst_ni, 1'b1, $onehot0(cell_hit))

endmodule

@@ rtl/core/chr_cell.sv @@
// one ring cell: holds a key and tag, compares, shifts up on insert
module chr_cell #(
  parameter int unsigned INDEX    = 0,
  parameter int unsigned CNT_W    = 9,
  parameter int unsigned TAG_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  chr_pkg::chr_cmd_t       cmd_i,
  input  logic [TAG_BITS-1:0]     new_tag_i,
  input  logic [CNT_W-1:0]        count_i,
  input  logic                    prev_ge_i,
  input  logic [chr_pkg::KEY_W-1:0] prev_key_i,
  input  logic [TAG_BITS-1:0]     prev_tag_i,
  output logic [chr_pkg::KEY_W-1:0] key_o,
  output logic [TAG_BITS-1:0]     tag_o,
  output logic                    ge_o,
  output logic                    eq_o,
  output logic                    hit_o,
  output logic [chr_pkg::KEY_W-1:0] sel_key_o,
  output logic [TAG_BITS-1:0]     sel_tag_o
);
  import chr_pkg::*;

  logic [KEY_W-1:0]    key_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                ge_q, eq_q;
  logic                occ;
  logic                at_end;

  assign occ    = CNT_W'(INDEX) < count_i;
  assign at_end = CNT_W'(INDEX) == count_i;

  // compare flags against the broadcast key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ge_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (cmd_i.cmp_en) begin
      ge_q <= occ && (key_q >= cmd_i.key);
      eq_q <= occ && (key_q == cmd_i.key);
    end
  end

  // sorted insert: cells above the slot take the neighbor's entry, the slot takes the new key
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && (ge_q || at_end)) begin
      if (prev_ge_i) begin
        key_q <= prev_key_i;
        tag_q <= prev_tag_i;
      end else begin
        key_q <= cmd_i.key;
        tag_q <= new_tag_i;
      end
    end
  end

  // first cell at or above the key is the hit
  assign hit_o     = ge_q && !prev_ge_i;
  assign sel_key_o = hit_o ? key_q : '0;
  assign sel_tag_o = hit_o ? tag_q : '0;
  assign key_o     = key_q;
  assign tag_o     = tag_q;
  assign ge_o      = ge_q;
  assign eq_o      = eq_q;

endmodule

@@ rtl/core/chr_reduce.sv @@
// two-stage registered or-tree over the cell row
module chr_reduce #(
  parameter int unsigned N        = 256,
  parameter int unsigned TAG_BITS = 8
) (
  input  logic                      clk_i,
  input  logic [N-1:0]              eq_i,
  input  logic [N-1:0]              ge_i,
  input  logic [chr_pkg::KEY_W-1:0] key_i [N],
  input  logic [TAG_BITS-1:0]       tag_i [N],
  output chr_pkg::chr_red_t         red_o
);
  import chr_pkg::*;

  localparam int unsigned GRP = 16;
  localparam int unsigned NG  = (N + GRP - 1) / GRP;

  logic [KEY_W-1:0]    grp_key_d [NG];
  logic [TAG_BITS-1:0] grp_tag_d [NG];
  logic [NG-1:0]       grp_eq_d, grp_ge_d;
  logic [KEY_W-1:0]    grp_key_q [NG];
  logic [TAG_BITS-1:0] grp_tag_q [NG];
  logic [NG-1:0]       grp_eq_q, grp_ge_q;
  chr_red_t            red_d, red_q;

  // first level: or within each group of cells
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_key_d[g] = '0;
      grp_tag_d[g] = '0;
      grp_eq_d[g]  = 1'b0;
      grp_ge_d[g]  = 1'b0;
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < N) begin
          grp_key_d[g] = grp_key_d[g] | key_i[g*GRP+j];
          grp_tag_d[g] = grp_tag_d[g] | tag_i[g*GRP+j];
          grp_eq_d[g]  = grp_eq_d[g] | eq_i[g*GRP+j];
          grp_ge_d[g]  = grp_ge_d[g] | ge_i[g*GRP+j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_key_q <= grp_key_d;
    grp_tag_q <= grp_tag_d;
    grp_eq_q  <= grp_eq_d;
    grp_ge_q  <= grp_ge_d;
  end

  // second level: or across groups
  always_comb begin
    red_d        = '0;
    red_d.eq_any = |grp_eq_q;
    red_d.ge_any = |grp_ge_q;
    for (int g = 0; g < NG; g++) begin
      red_d.key = red_d.key | grp_key_q[g];
      red_d.tag = red_d.tag | TAG_MAX_W'(grp_tag_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    red_q <= red_d;
  end

  assign red_o = red_q;

endmodule

@@ sim/consistent_hash_ring_core_tb.sv @@
`timescale 1ns / 100ps
// testbench for the hash ring core: shadow ring predictor, random stream traffic, result checks
module consistent_hash_ring_core_tb;
  import chr_pkg::*;

  localparam int unsigned RING_CAP     = 256;
  localparam int unsigned PROBES       = 32;
  localparam int unsigned TAG_W        = 8;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned STALL_LIMIT  = 2000;
  // slowest item: every probe collides, plus some margin
  localparam int unsigned DRAIN_CYCLES = 4 * (PROBES + 1) + 1 + 20;

  // one result as the block should return it
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [TAG_W-1:0]     owner;
    logic [KEY_W-1:0]     placed;
  } ring_answer_t;

  // shadow copy of the sorted ring and the results still owed by the block
  class ring_shadow;
    logic [KEY_W-1:0] point_key [RING_CAP];
    logic [TAG_W-1:0] point_tag [RING_CAP];
    int unsigned      fill;
    ring_answer_t     answers_due [$];
    int unsigned      mismatch_count;

    function new();
      fill = 0;
      mismatch_count = 0;
    endfunction

    // first slot holding a key at or above k, fill if none
    function int unsigned slot_at_or_above(logic [KEY_W-1:0] k);
      for (int unsigned i = 0; i < fill; i++) begin
        if (point_key[i] >= k) return i;
      end
      return fill;
    endfunction

    function bit holds_key(logic [KEY_W-1:0] k);
      int unsigned p;
      p = slot_at_or_above(k);
      return (p < fill) && (point_key[p] == k);
    endfunction

    // shift the upper part up by one and drop the new point in
    function void place_sorted(logic [KEY_W-1:0] k, logic [TAG_W-1:0] tag);
      int unsigned p;
      p = slot_at_or_above(k);
      for (int unsigned i = fill; i > p; i--) begin
        point_key[i] = point_key[i-1];
        point_tag[i] = point_tag[i-1];
      end
      point_key[p] = k;
      point_tag[p] = tag;
      fill++;
    endfunction

    // apply one request to the shadow ring and work out its result
    function ring_answer_t resolve(logic op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
      ring_answer_t ans;
      logic [KEY_W-1:0] run;
      int unsigned p;
      ans = '0;
      if (op == OP_INSERT) begin
        if (fill >= RING_CAP) begin
          ans.status = ST_FULL;
        end else if (!holds_key(key)) begin
          place_sorted(key, tag);
          ans.status = ST_INSERTED;
          ans.placed = key;
        end else begin
          // probe i steps the running key by 2^i - 1
          ans.status = ST_COLLIDED;
          run = key;
          for (int i = 0; i < PROBES; i++) begin
            run = run + ((32'd1 << i) - 32'd1);
            if (!holds_key(run)) begin
              place_sorted(run, tag);
              ans.status = ST_INSERTED;
              ans.placed = run;
              break;
            end
          end
        end
      end else if (fill == 0) begin
        ans.status = ST_EMPTY;
      end else begin
        // successor lookup, wrapping to the smallest key
        p = slot_at_or_above(key);
        if (p >= fill) p = 0;
        ans.status = ST_FOUND;
        ans.owner  = point_tag[p];
        ans.placed = point_key[p];
      end
      return ans;
    endfunction

    function void note_request(logic op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
      answers_due.push_back(resolve(op, key, tag));
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
    endtask

    // compare one output transfer with the oldest owed result
    task check_answer(logic [STATUS_W-1:0] status, logic [39:0] tdata);
      ring_answer_t want;
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding, status %0d", status));
        return;
      end
      want = answers_due.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", status, want.status));
      if (tdata[7:0] !== want.owner)
        report_mismatch($sformatf("owner_tag got %0h want %0h", tdata[7:0], want.owner));
      if (tdata[39:8] !== want.placed)
        report_mismatch($sformatf("placed_key got %08h want %08h", tdata[39:8], want.placed));
    endtask

    task flag_leftover();
      foreach (answers_due[i])
        report_mismatch($sformatf("result never came, status %0d key %08h",
                                  answers_due[i].status, answers_due[i].placed));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // key[31:0], node_tag[39:32]
  logic        s_axis_tuser;   // opcode[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // owner_tag[7:0], placed_key[39:8]
  logic [2:0]  m_axis_tuser;   // status[2:0]

  ring_shadow  ring;
  bit          calm;
  int unsigned sent;
  int unsigned idle_cycles;

  consistent_hash_ring_core #(
    .RING_CAPACITY(RING_CAP),
    .PROBE_LIMIT  (PROBES),
    .TAG_BITS     (TAG_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input transfer, with a random gap before it
  task automatic send_item(logic op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tuser  <= op;
    s_axis_tdata  <= {tag, key};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    ring.note_request(op, key, tag);
    sent++;
  endtask

  // a stored key moved by up to spread, or any key on an empty ring
  function automatic logic [KEY_W-1:0] ring_point_near(int unsigned spread);
    logic [KEY_W-1:0] k;
    if (ring.fill == 0) return $urandom;
    k = ring.point_key[$urandom_range(0, ring.fill - 1)];
    return k + $urandom_range(0, 2 * spread) - spread;
  endfunction

  // output side: random stalls, check every result transfer
  initial begin
    int unsigned hold;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      ring.check_answer(m_axis_tuser, m_axis_tdata);
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned start;
    int unsigned pick;
    int unsigned chains;
    int unsigned skip;
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] run;

    ring          = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_INSERT;
    calm          = 1'b0;
    sent          = 0;
    chains        = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty ring, wrap-around, field extremes, collisions with 32-bit wrap
    send_item(OP_LOOKUP, 32'h0000_0000, 8'h00);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 8'hFF);
    send_item(OP_INSERT, 32'h8000_0000, 8'hAA);
    send_item(OP_LOOKUP, 32'hC000_0000, 8'h00);
    send_item(OP_LOOKUP, 32'h0000_0000, 8'h00);
    send_item(OP_INSERT, 32'h0000_0000, 8'hFF);
    send_item(OP_LOOKUP, 32'hFFFF_FFF0, 8'hFF);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 8'h01);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 8'h55);
    send_item(OP_INSERT, 32'h8000_0000, 8'h00);
    send_item(OP_INSERT, 32'h8000_0000, 8'h7F);
    send_item(OP_INSERT, 32'h0000_0003, 8'h80);
    send_item(OP_LOOKUP, 32'h0000_0001, 8'h00);
    send_item(OP_LOOKUP, 32'h8000_0002, 8'h00);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 8'h00);
    send_item(OP_LOOKUP, 32'h8000_0000, 8'hFF);

    // random traffic: fills the ring, then keeps hitting the full ring
    start = sent;
    while (sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      pick = $urandom_range(0, 99);
      if (pick < 4 && chains < 4 && ring.fill + PROBES + 1 <= RING_CAP) begin
        // lay down every probe point of a base key, maybe leaving one out,
        // then insert the base so the probes run deep or all collide
        chains++;
        base = $urandom;
        run  = base;
        skip = $urandom_range(1, PROBES);
        for (int i = 0; i < PROBES; i++) begin
          run = run + ((32'd1 << i) - 32'd1);
          if (i != skip) send_item(OP_INSERT, run, $urandom_range(0, 255));
        end
        send_item(OP_INSERT, base, $urandom_range(0, 255));
      end else if (pick < 46) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send_item(OP_INSERT, $urandom, $urandom_range(0, 255));
          6, 7:             send_item(OP_INSERT, ring_point_near(0), $urandom_range(0, 255));
          default:          send_item(OP_INSERT, ring_point_near(20), $urandom_range(0, 255));
        endcase
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: send_item(OP_LOOKUP, $urandom, $urandom_range(0, 255));
          5, 6:          send_item(OP_LOOKUP, ring_point_near(0), $urandom_range(0, 255));
          default:       send_item(OP_LOOKUP, ring_point_near(1), $urandom_range(0, 255));
        endcase
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then watch for stray results
    while (ring.answers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    ring.flag_leftover();
    if (ring.mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
